### rtl/lgse_pkg.sv
// Shared types, constants and helper functions of the light grid splat engine.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lgse_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int CSR_DATA_W  = 9;
   localparam int RECIP_SHIFT = 18;

   localparam logic [17:0] ONE_VAL    = 18'(1) << FRAC_BITS;
   localparam logic [17:0] LEVEL_BIAS = 18'(((95 << FRAC_BITS) + 50) / 100);

   // reciprocals scaled by 2**RECIP_SHIFT
   localparam logic signed [19:0] RECIP5 = 20'sd52429;
   localparam logic signed [19:0] RECIP3 = 20'sd87382;
   localparam logic signed [19:0] UNITY  = 20'sd262144;

   localparam logic [2:0] CMD_MARK_CHANGED = 3'd0;
   localparam logic [2:0] CMD_MARK_CONTRIB = 3'd1;
   localparam logic [2:0] CMD_APPLY_SOURCE = 3'd2;
   localparam logic [2:0] CMD_CLEAR_FLAGS  = 3'd3;
   localparam logic [2:0] CMD_READ         = 3'd4;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_W-1:0] GRID_RESET = 9'd64;

   localparam int FLAG_CHANGED = 0;
   localparam int FLAG_CONTRIB = 1;

   typedef struct packed {
      logic [2:0]         command;
      logic [11:0]        cell_index;
      logic [7:0]         source_x;
      logic [7:0]         source_y;
      logic [16:0]        color_red;
      logic [16:0]        color_green;
      logic [16:0]        color_blue;
      logic [16:0]        light_level;
      logic signed [15:0] room_height;
      logic               ceiling_sky;
      logic               floor_sky;
   } req_type;

   typedef struct packed {
      logic [16:0]       out_red;
      logic [16:0]       out_green;
      logic [16:0]       out_blue;
      logic signed [7:0] out_bias;
      logic              out_pending;
   } rsp_type;

   typedef struct packed {
      logic [16:0] r;
      logic [16:0] g;
      logic [16:0] b;
   } rgb_type;

   typedef struct packed {
      rgb_type           rgb;
      rgb_type           saved;
      logic signed [7:0] bias;
   } cell_word_type;

   localparam int CELL_W = $bits(cell_word_type);

   localparam logic [4:0] WEIGHT_TAB [25] = '{
      5'd2, 5'd4,  5'd5,  5'd4,  5'd2,
      5'd4, 5'd8,  5'd10, 5'd8,  5'd4,
      5'd5, 5'd10, 5'd20, 5'd10, 5'd5,
      5'd4, 5'd8,  5'd10, 5'd8,  5'd4,
      5'd2, 5'd4,  5'd5,  5'd4,  5'd2
   };

   function automatic logic [4:0] weight_of(logic [2:0] dy, logic [2:0] dx);
      logic [4:0] i;
      i = 5'(dy) * 5'd5 + 5'(dx);
      return WEIGHT_TAB[i];
   endfunction

   // w/160 of one: total shift and whether a divide by five follows
   function automatic logic [4:0] gain_shift(logic [4:0] w);
      case (w)
         5'd2:    return 5'd20;
         5'd4:    return 5'd19;
         5'd5:    return 5'd21;
         5'd8:    return 5'd18;
         5'd10:   return 5'd20;
         5'd20:   return 5'd19;
         default: return 5'd21;
      endcase
   endfunction

   function automatic logic gain_div5(logic [4:0] w);
      return (w == 5'd2) || (w == 5'd4) || (w == 5'd8);
   endfunction

   function automatic logic [16:0] sat_add(logic [16:0] cur, logic [39:0] p);
      logic [17:0] c;
      logic [18:0] s;
      c = p[35:18];
      if (c > ONE_VAL) c = ONE_VAL;
      s = 19'(cur) + 19'(c);
      if (s > 19'(ONE_VAL)) s = 19'(ONE_VAL);
      return s[16:0];
   endfunction

endpackage

### rtl/lgse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lgse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_in;

   assign rd_data_in = mem_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= rd_data_in;
   end

endmodule

### rtl/lgse_mul.sv
// Shared signed 20x20 multiplier with registered product.
// No dependencies.
`timescale 1ns / 1ps

module lgse_mul (
   input  logic               clock,
   input  logic signed [19:0] op_a,
   input  logic signed [19:0] op_b,
   output logic signed [39:0] product_ff
);

   logic signed [39:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### rtl/light_grid_splat_engine_unit.sv
// Light grid splat engine top level: sequencer, cell RAMs and shared multiplier.
// Depends on lgse_pkg, lgse_ram and lgse_mul.
//
//   channel  ports                          direction  handshake
//   request  req_valid/req_ready/req_payload  in       valid/ready
//   response rsp_valid/rsp_ready/rsp_payload  out      valid/ready
//   csr      csr_wr_en/csr_index/csr_wr_data  in       write enable
//
// Mark and read requests pass through ST_RD0 and ST_RD1; clear_flags sweeps the flag
// RAM over every cell. apply_source steps through ST_AS0 to ST_AS5 and then through
// ST_NB0 up to ST_NB8 per neighbor, on the single multiplier and the one RAM read port.
// After reset a clearing pass zeroes both RAMs; no request is taken meanwhile. A
// read stalls in ST_RD1 while the response register still holds an untaken response.
`timescale 1ns / 1ps

module light_grid_splat_engine_unit #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lgse_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lgse_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_wr_en,
   input  logic                               csr_index,
   input  logic [lgse_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import lgse_pkg::*;

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam logic [19:0] CELLS = 20'(MAX_CELLS);

   typedef enum logic [19:0] {
      ST_CLEAR = 20'h00001,
      ST_IDLE  = 20'h00002,
      ST_FLAGS = 20'h00004,
      ST_RD0   = 20'h00008,
      ST_RD1   = 20'h00010,
      ST_AS0   = 20'h00020,
      ST_AS1   = 20'h00040,
      ST_AS2   = 20'h00080,
      ST_AS3   = 20'h00100,
      ST_AS4   = 20'h00200,
      ST_AS5   = 20'h00400,
      ST_NB0   = 20'h00800,
      ST_NB1   = 20'h01000,
      ST_NB2   = 20'h02000,
      ST_NB3   = 20'h04000,
      ST_NB4   = 20'h08000,
      ST_NB5   = 20'h10000,
      ST_NB6   = 20'h20000,
      ST_NB7   = 20'h40000,
      ST_NB8   = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CSR_DATA_W-1:0] gw_ff, gw_in, gh_ff, gh_in;
   logic [2:0] dx_ff, dx_in, dy_ff, dy_in;
   logic rsp_valid_ff, rsp_valid_in;

   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic [17:0] lev_ff, lev_in;
   logic signed [15:0] src_bias_ff, src_bias_in;
   logic [34:0] t_r_ff, t_r_in, t_g_ff, t_g_in, t_b_ff, t_b_in;
   logic [AW-1:0] nidx_ff, nidx_in;
   cell_word_type cell_ff, cell_in;
   logic signed [20:0] p1_ff, p1_in;
   logic neg_ff, neg_in;

   logic signed [19:0] mul_a, mul_b;
   logic signed [39:0] prod;
   logic [AW-1:0] rd_addr, data_waddr, flag_waddr;
   logic data_we, flag_we;
   cell_word_type data_wdata, data_rd;
   logic [1:0] flag_wdata, flag_rd;

   lgse_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CELLS)) u_data_ram (
      .clock(clock), .wr_en(data_we), .wr_addr(data_waddr), .wr_data(data_wdata),
      .rd_addr(rd_addr), .rd_data_ff(data_rd)
   );

   lgse_ram #(.WIDTH(2), .DEPTH(MAX_CELLS)) u_flag_ram (
      .clock(clock), .wr_en(flag_we), .wr_addr(flag_waddr), .wr_data(flag_wdata),
      .rd_addr(rd_addr), .rd_data_ff(flag_rd)
   );

   lgse_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .product_ff(prod));

   // helpers
   logic idx_ok, clr_last, nb_last;
   logic [AW-1:0] idx_addr;
   logic [17:0] lvl2;
   logic signed [16:0] h_ext, h_minus;
   logic [16:0] h_abs;
   logic signed [15:0] q3s;
   logic [19:0] sidx, nidx;
   logic signed [10:0] ny, nx;
   logic ny_ok, nx_ok;
   logic [4:0] w_cur, sh_cur;
   logic [19:0] m_cur;
   logic [2:0] adv_dx, adv_dy;
   state_type adv_state;
   logic signed [20:0] n_sum;
   logic [20:0] n_abs;
   logic signed [14:0] nb_full;
   logic signed [7:0] nb_clamp;
   rgb_type rd_rgb;

   assign idx_ok   = 20'(req_ff.cell_index) < CELLS;
   assign idx_addr = AW'(req_ff.cell_index);
   assign clr_last = clr_cnt_ff == AW'(MAX_CELLS - 1);
   assign lvl2     = {req_ff.light_level, 1'b0};
   assign h_ext    = 17'(req_ff.room_height);
   assign h_minus  = h_ext - 17'sd100;
   assign h_abs    = h_ext[16] ? 17'(-h_ext) : 17'(h_ext);
   assign q3s      = $signed({1'b0, prod[32:18]});
   assign sidx     = prod[19:0] + 20'(req_ff.source_x);
   assign ny       = $signed({3'b0, req_ff.source_y}) + $signed({8'b0, dy_ff}) - 11'sd2;
   assign nx       = $signed({3'b0, req_ff.source_x}) + $signed({8'b0, dx_ff}) - 11'sd2;
   assign ny_ok    = !ny[10] && (ny[9:0] < {1'b0, gh_ff});
   assign nx_ok    = !nx[10] && (nx[9:0] < {1'b0, gw_ff});
   assign nidx     = prod[19:0] + 20'(nx[9:0]);
   assign w_cur    = weight_of(dy_ff, dx_ff);
   assign sh_cur   = gain_shift(w_cur);
   assign m_cur    = gain_div5(w_cur) ? RECIP5 : UNITY;
   assign nb_last  = (dx_ff == 3'd4) && (dy_ff == 3'd4);
   assign adv_dx   = (dx_ff == 3'd4) ? 3'd0 : dx_ff + 3'd1;
   assign adv_dy   = nb_last ? 3'd0 : ((dx_ff == 3'd4) ? dy_ff + 3'd1 : dy_ff);
   assign adv_state = nb_last ? ST_IDLE : ST_NB0;
   assign n_sum    = p1_ff + $signed(prod[20:0]);
   assign n_abs    = n_sum[20] ? 21'(-n_sum) : 21'(n_sum);
   assign nb_full  = neg_ff ? -$signed({1'b0, prod[31:18]}) : $signed({1'b0, prod[31:18]});
   assign nb_clamp = (nb_full < -15'sd128) ? -8'sd128 :
                     (nb_full > 15'sd127) ? 8'sd127 : 8'(nb_full);
   assign rd_rgb   = flag_rd[FLAG_CHANGED] ? data_rd.saved : data_rd.rgb;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      gw_in       = gw_ff;
      gh_in       = gh_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      lev_in      = lev_ff;
      src_bias_in = src_bias_ff;
      t_r_in      = t_r_ff;
      t_g_in      = t_g_ff;
      t_b_in      = t_b_ff;
      nidx_in     = nidx_ff;
      cell_in     = cell_ff;
      p1_in       = p1_ff;
      neg_in      = neg_ff;
      mul_a       = '0;
      mul_b       = '0;
      rd_addr     = nidx_ff;
      data_we     = 1'b0;
      data_waddr  = nidx_ff;
      data_wdata  = cell_ff;
      flag_we     = 1'b0;
      flag_waddr  = nidx_ff;
      flag_wdata  = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:  gw_in = csr_wr_data;
            CSR_GRID_HEIGHT: gh_in = csr_wr_data;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            data_we    = 1'b1;
            flag_we    = 1'b1;
            data_waddr = clr_cnt_ff;
            flag_waddr = clr_cnt_ff;
            data_wdata = '0;
            clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               unique case (req_payload.command) inside
                  CMD_MARK_CHANGED, CMD_MARK_CONTRIB, CMD_READ: state_in = ST_RD0;
                  CMD_APPLY_SOURCE: state_in = ST_AS0;
                  CMD_CLEAR_FLAGS:  state_in = ST_FLAGS;
                  default:          state_in = ST_IDLE;
               endcase
            end
         end
         ST_FLAGS: begin
            flag_we    = 1'b1;
            flag_waddr = clr_cnt_ff;
            clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
            if (clr_last) state_in = ST_IDLE;
         end
         ST_RD0: begin
            rd_addr  = idx_addr;
            state_in = (idx_ok || req_ff.command == CMD_READ) ? ST_RD1 : ST_IDLE;
         end
         ST_RD1: begin
            rd_addr    = idx_addr;
            data_waddr = idx_addr;
            flag_waddr = idx_addr;
            if (req_ff.command == CMD_READ) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  if (idx_ok) begin
                     rsp_in.out_red     = rd_rgb.r;
                     rsp_in.out_green   = rd_rgb.g;
                     rsp_in.out_blue    = rd_rgb.b;
                     rsp_in.out_bias    = data_rd.bias;
                     rsp_in.out_pending = flag_rd[FLAG_CHANGED];
                  end else begin
                     rsp_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               flag_we = 1'b1;
               if (req_ff.command == CMD_MARK_CHANGED) begin
                  data_we          = 1'b1;
                  data_wdata.rgb   = '0;
                  data_wdata.saved = flag_rd[FLAG_CHANGED] ? data_rd.saved : data_rd.rgb;
                  data_wdata.bias  = data_rd.bias;
                  flag_wdata       = 2'b11;
               end else begin
                  flag_wdata = flag_rd | 2'b10;
               end
               state_in = ST_IDLE;
            end
         end
         ST_AS0: begin
            mul_a    = signed'(20'(req_ff.source_y));
            mul_b    = signed'(20'(gw_ff));
            lev_in   = (lvl2 > LEVEL_BIAS) ? lvl2 - LEVEL_BIAS : '0;
            state_in = ST_AS1;
         end
         ST_AS1: begin
            rd_addr = AW'(sidx);
            mul_a   = signed'(20'(h_abs >> 1));
            mul_b   = RECIP3;
            if (({1'b0, req_ff.source_x} < gw_ff) && ({1'b0, req_ff.source_y} < gh_ff) &&
                (sidx < CELLS) && (lev_ff != '0)) begin
               state_in = ST_AS2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_AS2: begin
            if (req_ff.ceiling_sky && !req_ff.floor_sky)
               src_bias_in = h_ext[16] ? q3s : -q3s;
            else if (!req_ff.ceiling_sky && req_ff.floor_sky)
               src_bias_in = h_ext[16] ? -q3s : q3s;
            else if (h_ext > 17'sd100)
               src_bias_in = 16'(h_minus >>> 1);
            else
               src_bias_in = '0;
            mul_a    = signed'(20'(req_ff.color_red));
            mul_b    = signed'(20'(lev_ff));
            state_in = flag_rd[FLAG_CONTRIB] ? ST_AS3 : ST_IDLE;
         end
         ST_AS3: begin
            t_r_in   = prod[34:0];
            mul_a    = signed'(20'(req_ff.color_green));
            mul_b    = signed'(20'(lev_ff));
            state_in = ST_AS4;
         end
         ST_AS4: begin
            t_g_in   = prod[34:0];
            mul_a    = signed'(20'(req_ff.color_blue));
            mul_b    = signed'(20'(lev_ff));
            state_in = ST_AS5;
         end
         ST_AS5: begin
            t_b_in   = prod[34:0];
            dx_in    = '0;
            dy_in    = '0;
            state_in = ST_NB0;
         end
         ST_NB0: begin
            mul_a = signed'(20'(ny[9:0]));
            mul_b = signed'(20'(gw_ff));
            if (ny_ok && nx_ok) begin
               state_in = ST_NB1;
            end else begin
               dx_in    = adv_dx;
               dy_in    = adv_dy;
               state_in = adv_state;
            end
         end
         ST_NB1: begin
            rd_addr = AW'(nidx);
            nidx_in = AW'(nidx);
            if (nidx < CELLS) begin
               state_in = ST_NB2;
            end else begin
               dx_in    = adv_dx;
               dy_in    = adv_dy;
               state_in = adv_state;
            end
         end
         ST_NB2: begin
            cell_in = data_rd;
            mul_a   = signed'(20'(17'(t_r_ff >> sh_cur)));
            mul_b   = m_cur;
            if (flag_rd[FLAG_CHANGED]) begin
               state_in = ST_NB3;
            end else begin
               dx_in    = adv_dx;
               dy_in    = adv_dy;
               state_in = adv_state;
            end
         end
         ST_NB3: begin
            cell_in.rgb.r = sat_add(cell_ff.rgb.r, prod);
            mul_a         = signed'(20'(17'(t_g_ff >> sh_cur)));
            mul_b         = m_cur;
            state_in      = ST_NB4;
         end
         ST_NB4: begin
            cell_in.rgb.g = sat_add(cell_ff.rgb.g, prod);
            mul_a         = signed'(20'(17'(t_b_ff >> sh_cur)));
            mul_b         = m_cur;
            state_in      = ST_NB5;
         end
         ST_NB5: begin
            cell_in.rgb.b = sat_add(cell_ff.rgb.b, prod);
            mul_a         = 20'(cell_ff.bias);
            mul_b         = 20'sd160 - signed'(20'(w_cur));
            state_in      = ST_NB6;
         end
         ST_NB6: begin
            p1_in    = $signed(prod[20:0]);
            mul_a    = 20'(src_bias_ff);
            mul_b    = signed'(20'(w_cur));
            state_in = ST_NB7;
         end
         ST_NB7: begin
            // trunc toward zero: divide the magnitude by 32 then by 5
            neg_in   = n_sum[20];
            mul_a    = signed'(20'(n_abs >> 5));
            mul_b    = RECIP5;
            state_in = ST_NB8;
         end
         ST_NB8: begin
            data_we         = 1'b1;
            data_wdata.bias = nb_clamp;
            dx_in           = adv_dx;
            dy_in           = adv_dy;
            state_in        = adv_state;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         gw_ff        <= GRID_RESET;
         gh_ff        <= GRID_RESET;
         dx_ff        <= '0;
         dy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      lev_ff      <= lev_in;
      src_bias_ff <= src_bias_in;
      t_r_ff      <= t_r_in;
      t_g_ff      <= t_g_in;
      t_b_ff      <= t_b_in;
      nidx_ff     <= nidx_in;
      cell_ff     <= cell_in;
      p1_ff       <= p1_in;
      neg_ff      <= neg_in;
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!data_we && !flag_we))
      else $error("RAM write while idle");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_FLAGS) |-> !req_ready)
      else $error("request taken during a sweep");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RD1))
      else $error("response raised outside read stage");

   a_nb_counters: assert property (@(posedge clock) disable iff (reset)
      (dx_ff <= 3'd4) && (dy_ff <= 3'd4))
      else $error("neighbor counter out of range");

   a_nb_write_bias: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NB8) |=> (state_ff == ST_NB0 || state_ff == ST_IDLE))
      else $error("bad step after neighbor write");

endmodule
